// ----- rtl/tacs_pkg.sv -----
// Shared types, constants and codes for the touch average, clamp and scale block.
package tacs_pkg;

  localparam int unsigned RAW_W        = 16;
  localparam int unsigned SCALE_W      = 12;
  localparam int unsigned DEN_W        = 16;
  localparam int unsigned PROD_W       = RAW_W + SCALE_W;
  localparam int unsigned SAMPLES_DEF  = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [RAW_W-1:0]   RAW_MIN_RST = 16'd0;
  localparam logic [RAW_W-1:0]   RAW_MAX_RST = 16'hFFFF;
  localparam logic [SCALE_W-1:0] WIDTH_RST   = 12'd320;
  localparam logic [SCALE_W-1:0] HEIGHT_RST  = 12'd240;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN  = 3'd0,
    REG_X_MAX  = 3'd1,
    REG_Y_MIN  = 3'd2,
    REG_Y_MAX  = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_EMIT
  } state_e;

  typedef enum logic {
    AXIS_X = 1'b0,
    AXIS_Y = 1'b1
  } axis_e;

  typedef struct packed {
    logic add;
    logic clear;
  } acc_ctrl_t;

endpackage

// ----- rtl/tacs_accum.sv -----
// Sample counter and running X/Y sums of the current pen-down run.
module tacs_accum import tacs_pkg::*; #(
  parameter int unsigned SAMPLES = SAMPLES_DEF,
  parameter int unsigned SUM_W   = RAW_W + $clog2(SAMPLES),
  parameter int unsigned CNT_W   = $clog2(SAMPLES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  acc_ctrl_t        ctrl_i,
  input  logic [RAW_W-1:0] sample_x_i,
  input  logic [RAW_W-1:0] sample_y_i,
  output logic [SUM_W-1:0] sum_x_o,
  output logic [SUM_W-1:0] sum_y_o,
  output logic             last_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d;

  always_comb begin
    priority if (ctrl_i.clear) begin
      cnt_d   = '0;
      sum_x_d = '0;
      sum_y_d = '0;
    end else if (ctrl_i.add) begin
      cnt_d   = cnt_q + CNT_W'(1);
      sum_x_d = sum_x_q + SUM_W'(sample_x_i);
      sum_y_d = sum_y_q + SUM_W'(sample_y_i);
    end else begin
      cnt_d   = cnt_q;
      sum_x_d = sum_x_q;
      sum_y_d = sum_y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
    end
  end

  assign sum_x_o = sum_x_q;
  assign sum_y_o = sum_y_q;
  assign last_o  = (cnt_q == CNT_W'(SAMPLES - 1));

endmodule

// ----- rtl/tacs_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module tacs_div import tacs_pkg::*; #(
  parameter int unsigned NUM_W = PROD_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next numerator bit, subtract when the divisor fits
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      num_d = {num_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ----- rtl/touch_average_clamp_scale.sv -----
// Top level: touch sample averaging, window clamp and screen scaling sequencer.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------
//   in      | input     | in_valid_i / in_stall_o   | pen_down_i, sample_x_i, sample_y_i
//   out     | output    | out_valid_o / out_stall_i | coords_valid_o, pos_x_o, pos_y_o
//   cfg     | input     | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// A pen-down sample that does not end a run is added to the run sums. A pen-up
// sample clears the pending result and goes to the emit state, which loads the
// output register. The sample that ends a run goes, per axis, through a state
// that averages (constant reciprocal multiply) and clamps, one that forms the
// product, one that starts the shared one-bit-a-cycle divider (NUM_W bits wide,
// 28 by default) and one that waits for its quotient, and then to the emit state.
// in_stall_o is high whenever the sequencer is busy. A result waits in the
// output register; the next sample is taken while it is still stalled, and
// only a further result waits for it to leave. Reset restores the register
// defaults and clears the run; no clearing pass is needed.
module touch_average_clamp_scale import tacs_pkg::*; #(
  parameter int unsigned SAMPLES = SAMPLES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // sample request
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  pen_down_i,
  input  logic [RAW_W-1:0]      sample_x_i,
  input  logic [RAW_W-1:0]      sample_y_i,
  // coordinate request
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  coords_valid_o,
  output logic [SCALE_W-1:0]    pos_x_o,
  output logic [SCALE_W-1:0]    pos_y_o,
  // register writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // sums must hold SAMPLES full-scale readings
  localparam int unsigned SUM_W = RAW_W + $clog2(SAMPLES);
  localparam int unsigned NUM_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;

  // average = (sum * ceil(2^AVG_SH / SAMPLES)) >> AVG_SH, exact for every SUM_W-bit sum
  localparam int unsigned AVG_SH  = SUM_W + $clog2(SAMPLES);
  localparam int unsigned RECIP_W = SUM_W + 2;
  localparam int unsigned AVG_PW  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((64'd1 << AVG_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

  // ---------------------------------------------------------------------------
  // Calibration registers
  // ---------------------------------------------------------------------------
  logic [RAW_W-1:0]   x_min_q, x_max_q, y_min_q, y_max_q;
  logic [SCALE_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q  <= RAW_MIN_RST;
      x_max_q  <= RAW_MAX_RST;
      y_min_q  <= RAW_MIN_RST;
      y_max_q  <= RAW_MAX_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_X_MIN:  x_min_q  <= cfg_data_i[RAW_W-1:0];
        REG_X_MAX:  x_max_q  <= cfg_data_i[RAW_W-1:0];
        REG_Y_MIN:  y_min_q  <= cfg_data_i[RAW_W-1:0];
        REG_Y_MAX:  y_max_q  <= cfg_data_i[RAW_W-1:0];
        REG_WIDTH:  width_q  <= cfg_data_i[SCALE_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[SCALE_W-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Run accumulator
  // ---------------------------------------------------------------------------
  acc_ctrl_t        acc_ctrl;
  logic [SUM_W-1:0] sum_x, sum_y;
  logic             run_last;

  tacs_accum #(
    .SAMPLES (SAMPLES),
    .SUM_W   (SUM_W),
    .CNT_W   ($clog2(SAMPLES))
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (acc_ctrl),
    .sample_x_i (sample_x_i),
    .sample_y_i (sample_y_i),
    .sum_x_o    (sum_x),
    .sum_y_o    (sum_y),
    .last_o     (run_last)
  );

  // ---------------------------------------------------------------------------
  // Shared divider
  // ---------------------------------------------------------------------------
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quot;

  tacs_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;
  axis_e  axis_q, axis_d;
  logic   in_take;
  logic   out_free;

  logic [SUM_W-1:0]   cur_sum;
  logic [RAW_W-1:0]   cur_lo, cur_hi;
  logic [SCALE_W-1:0] cur_scale;
  logic [AVG_PW-1:0]  avg_prod;
  logic [RAW_W-1:0]   avg, raw_lo_c, raw_c;
  logic               win_empty;
  logic [SCALE_W-1:0] scaled;

  logic [RAW_W-1:0]   raw_q;
  logic [PROD_W-1:0]  prod_q;
  logic [SCALE_W-1:0] res_x_q, res_y_q;
  logic               res_ok_q;

  logic               out_valid_q, out_valid_d;
  logic               out_ok_q;
  logic [SCALE_W-1:0] out_x_q, out_y_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // per-axis operand selection
  assign cur_sum   = (axis_q == AXIS_Y) ? sum_y    : sum_x;
  assign cur_lo    = (axis_q == AXIS_Y) ? y_min_q  : x_min_q;
  assign cur_hi    = (axis_q == AXIS_Y) ? y_max_q  : x_max_q;
  assign cur_scale = (axis_q == AXIS_Y) ? height_q : width_q;

  // divide the sum by SAMPLES with a constant reciprocal, truncating
  assign avg_prod  = AVG_PW'(cur_sum) * AVG_PW'(AVG_RECIP);
  assign avg       = avg_prod[AVG_SH +: RAW_W];

  // raise to min first, then lower to max
  assign raw_lo_c  = (avg < cur_lo) ? cur_lo : avg;
  assign raw_c     = (raw_lo_c > cur_hi) ? cur_hi : raw_lo_c;
  assign win_empty = (cur_hi <= cur_lo);
  assign scaled    = win_empty ? '0 : div_quot[SCALE_W-1:0];

  always_comb begin
    state_d        = state_q;
    axis_d         = axis_q;
    acc_ctrl.add   = 1'b0;
    acc_ctrl.clear = 1'b0;
    div_start      = 1'b0;
    div_num        = NUM_W'(prod_q);
    div_den        = cur_hi - cur_lo;
    unique case (state_q)
      S_IDLE: begin
        axis_d = AXIS_X;
        if (in_take) begin
          if (!pen_down_i) begin
            state_d = S_EMIT;
          end else begin
            acc_ctrl.add = 1'b1;
            if (run_last) begin
              state_d = S_AVG;
            end
          end
        end
      end
      S_AVG: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          if (axis_q == AXIS_X) begin
            axis_d  = AXIS_Y;
            state_d = S_AVG;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          acc_ctrl.clear = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= AXIS_X;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  // working registers of the current axis and the pending result
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_take && !pen_down_i) begin
      res_ok_q <= 1'b0;
      res_x_q  <= '0;
      res_y_q  <= '0;
    end
    if (state_q == S_AVG) begin
      raw_q <= raw_c;
    end
    if (state_q == S_MUL) begin
      prod_q <= PROD_W'(raw_q - cur_lo) * PROD_W'(cur_scale);
    end
    if (state_q == S_DIV_WAIT && div_done) begin
      res_ok_q <= 1'b1;
      if (axis_q == AXIS_X) begin
        res_x_q <= scaled;
      end else begin
        res_y_q <= scaled;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (state_q == S_EMIT && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_free) begin
      out_ok_q <= res_ok_q;
      out_x_q  <= res_x_q;
      out_y_q  <= res_y_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign coords_valid_o = out_ok_q;
  assign pos_x_o        = out_x_q;
  assign pos_y_o        = out_y_q;

endmodule

// ----- rtl/tacs_checker.sv -----
// Port-level checks for the touch average, clamp and scale block, with its bind.
module tacs_checker import tacs_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               pen_down_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               coords_valid_o,
  input logic [SCALE_W-1:0] pos_x_o,
  input logic [SCALE_W-1:0] pos_y_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a released-pen result carries zero coordinates
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !coords_valid_o |-> (pos_x_o == '0) && (pos_y_o == '0))
    else $error("invalid result with nonzero coordinates");

  // a pen-up request always leads to a result stage
  a_penup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !pen_down_i |=> in_stall_o)
    else $error("pen-up request did not start a result");

  // a new result is only loaded by a busy sequencer
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without sequencer activity");

endmodule

bind touch_average_clamp_scale tacs_checker u_tacs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .pen_down_i     (pen_down_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .coords_valid_o (coords_valid_o),
  .pos_x_o        (pos_x_o),
  .pos_y_o        (pos_y_o)
);
